// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the packetizer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define MPK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that holds during reset as well.
`define MPK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mpk_pkg.sv =====
// Shared types and constants of the program-stream packetizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package mpk_pkg;

   // Default packet size in bytes
   localparam int MPK_PKT_SIZE = 2048;

   // Fixed field widths
   localparam int MPK_OFF_W   = 24;
   localparam int MPK_TICK_W  = 32;
   localparam int MPK_PAD_W   = 12;
   localparam int MPK_PROD_W  = MPK_OFF_W + MPK_TICK_W;
   localparam int MPK_DCNT_W  = $clog2(MPK_PROD_W + 1);
   localparam int MPK_IDX_W   = 5;

   // Header lengths
   localparam logic [MPK_IDX_W-1:0] MPK_HDR_BASE  = 5'd11;
   localparam logic [MPK_IDX_W-1:0] MPK_SCR_BYTES = 5'd8;
   localparam logic [MPK_IDX_W-1:0] MPK_AC3_BYTES = 5'd4;
   localparam logic [MPK_IDX_W-1:0] MPK_SCR_POS   = 5'd4;

   // Header byte values
   localparam logic [7:0] MPK_START_PFX = 8'h01;
   localparam logic [7:0] MPK_PACK_CODE = 8'hba;
   localparam logic [7:0] MPK_AC3_SID   = 8'hbd;
   localparam logic [7:0] MPK_FLAG_BYTE = 8'h0f;

   // Register indexes on the configuration port
   localparam logic MPK_REG_PACK_MODE = 1'b0;
   localparam logic MPK_REG_AC3_MODE  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DSTART,
      ST_DIV,
      ST_HDR,
      ST_BYTE
   } mpk_state_type;

   typedef struct packed {
      logic accept;
      logic mul_en;
      logic div_start;
      logic hdr_load;
      logic byte_load;
   } mpk_cmd_type;

   typedef struct packed {
      logic need_hdr;
      logic need_clk;
      logic div_busy;
      logic div_done;
      logic hdr_last;
      logic out_free;
   } mpk_sts_type;

endpackage

`default_nettype wire

// ===== rtl/mpk_div.sv =====
// Restoring divider, one quotient bit per cycle, for the clock interpolation.
// Depends on mpk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mpk_div (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   input  wire  [mpk_pkg::MPK_PROD_W-1:0]        dividend,
   input  wire  [mpk_pkg::MPK_OFF_W-1:0]         divisor,
   output logic                                  busy,
   output logic                                  done,
   output logic [mpk_pkg::MPK_TICK_W-1:0]        quotient,
   output logic                                  rem_nz
);
   import mpk_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [MPK_DCNT_W-1:0]  cnt_ff, cnt_in;
   logic [MPK_PROD_W-1:0]  dvd_ff, dvd_in;
   logic [MPK_OFF_W-1:0]   rem_ff, rem_in;
   logic [MPK_TICK_W-1:0]  quo_ff, quo_in;
   logic [MPK_OFF_W:0]     trial;
   logic                   fits;

   // One shift-subtract step
   always_comb begin
      trial = {rem_ff, dvd_ff[MPK_PROD_W-1]};
      fits  = trial >= {1'b0, divisor};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = MPK_DCNT_W'(MPK_PROD_W);
         dvd_in  = dividend;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[MPK_PROD_W-2:0], 1'b0};
         rem_in = fits ? MPK_OFF_W'(trial - {1'b0, divisor}) : trial[MPK_OFF_W-1:0];
         // upper quotient bits fall off: only the low word is kept
         quo_in = {quo_ff[MPK_TICK_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == MPK_DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;
   assign rem_nz   = rem_ff != '0;

endmodule

`default_nettype wire

// ===== rtl/mpk_ctrl.sv =====
// Packetizer controller: sequences accept, clock interpolation, header and payload.
// Depends on mpk_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mpk_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  mpk_pkg::mpk_sts_type   sts,
   output mpk_pkg::mpk_cmd_type   cmd
);
   import mpk_pkg::*;

   mpk_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (sts.need_clk)      state_in = ST_MUL;
               else if (sts.need_hdr) state_in = ST_HDR;
               else                   state_in = ST_BYTE;
            end
         end
         ST_MUL:    state_in = ST_DSTART;
         ST_DSTART: state_in = ST_DIV;
         ST_DIV: begin
            if (sts.div_done) state_in = ST_HDR;
         end
         ST_HDR: begin
            if (sts.out_free && sts.hdr_last) state_in = ST_BYTE;
         end
         ST_BYTE: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath; no transfer is taken while reset is high
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = !reset;
            cmd.accept = req_valid && !reset;
         end
         ST_MUL:    cmd.mul_en    = 1'b1;
         ST_DSTART: cmd.div_start = 1'b1;
         ST_DIV:    ;
         ST_HDR:    cmd.hdr_load  = sts.out_free;
         ST_BYTE:   cmd.byte_load = sts.out_free;
         default:   ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `MPK_ASSERT_ALWAYS(a_one_load, clock, !(cmd.hdr_load && cmd.byte_load), "two loads at once")
   `MPK_ASSERT(a_done_in_div, clock, reset, (sts.div_done |-> state_ff == ST_DIV), "stray div done")
   `MPK_ASSERT(a_hdr_no_div, clock, reset, (state_ff == ST_HDR |-> !sts.div_busy), "header during div")

endmodule

`default_nettype wire

// ===== rtl/mpk_dp.sv =====
// Packetizer datapath: input hold, stream state, clock interpolation, header
// bytes and the output register. Depends on mpk_pkg, mpk_div, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mpk_dp #(
   parameter int PKT_SIZE = mpk_pkg::MPK_PKT_SIZE
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                pack_mode,
   input  wire                                ac3_mode,
   input  wire  [7:0]                         req_data_byte,
   input  wire  [7:0]                         req_stream_id,
   input  wire                                req_seg_first,
   input  wire  [mpk_pkg::MPK_OFF_W-1:0]      req_seg_bytes,
   input  wire  [mpk_pkg::MPK_TICK_W-1:0]     req_start_ticks,
   input  wire  [mpk_pkg::MPK_TICK_W-1:0]     req_end_ticks,
   input  mpk_pkg::mpk_cmd_type               cmd,
   output mpk_pkg::mpk_sts_type               sts,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_run_last,
   output logic                               rsp_packet_end,
   output logic [mpk_pkg::MPK_PAD_W-1:0]      rsp_pad_owed
);
   import mpk_pkg::*;

   localparam int PL_W = $clog2(PKT_SIZE + 1);
   localparam logic [PL_W-1:0] PL_FULL   = PL_W'(PKT_SIZE);
   localparam logic [15:0]     LEN_SHORT = 16'(PKT_SIZE - 10);
   localparam logic [15:0]     LEN_LONG  = 16'(PKT_SIZE - 18);

   // Held input item
   logic [7:0]            data_ff, sid_ff;
   logic [MPK_OFF_W-1:0]  segb_ff;
   logic [MPK_TICK_W-1:0] start_ff, end_ff;

   // Stream state
   logic [MPK_OFF_W-1:0]  off_ff, off_in;
   logic [PL_W-1:0]       pl_ff, pl_in;
   logic [MPK_IDX_W-1:0]  idx_ff, idx_in;
   logic [MPK_TICK_W-1:0] clk_ff;

   // Interpolation
   logic                  neg_ff;
   logic [MPK_PROD_W-1:0] prod_ff;
   logic [MPK_TICK_W:0]   diff;
   logic [MPK_TICK_W-1:0] mag;
   logic                  div_busy, div_done, div_rem_nz;
   logic [MPK_TICK_W-1:0] div_q, q_adj;

   // Output register
   logic                  out_valid_ff, out_valid_in;
   logic [7:0]            out_byte_ff, out_byte_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_pe_ff, out_pe_in;
   logic [MPK_PAD_W-1:0]  out_pad_ff, out_pad_in;

   // Header shape and payload step
   logic [MPK_IDX_W-1:0]  hdr_len;
   logic [MPK_IDX_W-1:0]  hdr_last_idx;
   logic [PL_W-1:0]       pl_start;
   logic [15:0]           len_field;
   logic [PL_W-1:0]       pl_dec;
   logic [MPK_OFF_W-1:0]  off_inc;
   logic                  out_free;

   function automatic logic [7:0] hdr_byte(
      input logic [MPK_IDX_W-1:0]  idx,
      input logic                  pack,
      input logic                  ac3,
      input logic [7:0]            sid,
      input logic [MPK_TICK_W-1:0] t,
      input logic [15:0]           len
   );
      logic [MPK_IDX_W-1:0] j;
      begin
         // without the clock reference the later bytes move up
         j = (!pack && idx >= MPK_SCR_POS) ? idx + MPK_SCR_BYTES : idx;
         case (j)
            5'd2:    hdr_byte = MPK_START_PFX;
            5'd3:    hdr_byte = MPK_PACK_CODE;
            5'd4:    hdr_byte = {2'b00, 1'b1, 2'b00, t[31], t[30], 1'b1};
            5'd5:    hdr_byte = t[29:22];
            5'd6:    hdr_byte = {t[21:15], 1'b1};
            5'd7:    hdr_byte = t[14:7];
            5'd8:    hdr_byte = {t[6:0], 1'b1};
            5'd14:   hdr_byte = MPK_START_PFX;
            5'd15:   hdr_byte = ac3 ? MPK_AC3_SID : sid;
            5'd16:   hdr_byte = len[15:8];
            5'd17:   hdr_byte = len[7:0];
            5'd18:   hdr_byte = MPK_FLAG_BYTE;
            5'd19:   hdr_byte = sid;
            default: hdr_byte = 8'h00;
         endcase
      end
   endfunction

   // Header length for the current modes
   always_comb begin
      hdr_len      = MPK_HDR_BASE + (pack_mode ? MPK_SCR_BYTES : '0)
                     + (ac3_mode ? MPK_AC3_BYTES : '0);
      hdr_last_idx = hdr_len - 1'b1;
      pl_start     = PL_FULL - PL_W'(hdr_len);
      len_field    = pack_mode ? LEN_LONG : LEN_SHORT;
   end

   // |end - start| and its sign
   always_comb begin
      diff = {1'b0, end_ff} - {1'b0, start_ff};
      mag  = diff[MPK_TICK_W] ? (~diff[MPK_TICK_W-1:0] + 1'b1) : diff[MPK_TICK_W-1:0];
   end

   mpk_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (segb_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q),
      .rem_nz   (div_rem_nz)
   );

   // Floor for a negative numerator: -q, one less on a remainder
   assign q_adj = neg_ff ? (~div_q + {{(MPK_TICK_W-1){1'b0}}, !div_rem_nz}) : div_q;

   assign out_free = !out_valid_ff || rsp_ready;
   assign pl_dec   = pl_ff - 1'b1;
   assign off_inc  = off_ff + 1'b1;

   // Stream state and output register
   always_comb begin
      off_in       = off_ff;
      pl_in        = pl_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_pe_in    = out_pe_ff;
      out_pad_in   = out_pad_ff;
      if (cmd.accept) begin
         idx_in = '0;
         if (req_seg_first) begin
            off_in = '0;
            pl_in  = '0;
         end
      end
      if (cmd.hdr_load) begin
         out_valid_in = 1'b1;
         out_byte_in  = hdr_byte(idx_ff, pack_mode, ac3_mode, sid_ff, clk_ff, len_field);
         out_last_in  = 1'b0;
         out_pe_in    = 1'b0;
         out_pad_in   = '0;
         idx_in       = idx_ff + 1'b1;
         if (idx_ff == hdr_last_idx) pl_in = pl_start;
      end
      if (cmd.byte_load) begin
         out_valid_in = 1'b1;
         out_byte_in  = data_ff;
         out_last_in  = 1'b1;
         out_pe_in    = 1'b0;
         out_pad_in   = '0;
         off_in       = off_inc;
         pl_in        = pl_dec;
         if (pl_dec == '0) begin
            out_pe_in = 1'b1;
         end else if (off_inc >= segb_ff) begin
            // segment finished with room left: close and report filler
            out_pe_in  = 1'b1;
            out_pad_in = MPK_PAD_W'(pl_dec);
            pl_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff       <= '0;
         pl_ff        <= '0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         off_ff       <= off_in;
         pl_ff        <= pl_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_pe_ff   <= out_pe_in;
      out_pad_ff  <= out_pad_in;
   end

   // Input hold, product and clock reference
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         data_ff  <= req_data_byte;
         sid_ff   <= req_stream_id;
         segb_ff  <= req_seg_bytes;
         start_ff <= req_start_ticks;
         end_ff   <= req_end_ticks;
      end
      if (cmd.mul_en) begin
         prod_ff <= MPK_PROD_W'(off_ff) * MPK_PROD_W'(mag);
         neg_ff  <= diff[MPK_TICK_W];
      end
      if (div_done) begin
         clk_ff <= (segb_ff == '0) ? start_ff : start_ff + q_adj;
      end
   end

   // Status
   always_comb begin
      sts.need_hdr = req_seg_first || (pl_ff == '0);
      sts.need_clk = sts.need_hdr && pack_mode;
      sts.div_busy = div_busy;
      sts.div_done = div_done;
      sts.hdr_last = idx_ff == hdr_last_idx;
      sts.out_free = out_free;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_run_last   = out_last_ff;
   assign rsp_packet_end = out_pe_ff;
   assign rsp_pad_owed   = out_pad_ff;

   `MPK_ASSERT(a_byte_open, clock, reset, (cmd.byte_load |-> pl_ff != '0), "payload with no packet open")
   `MPK_ASSERT(a_idx_range, clock, reset, (cmd.hdr_load |-> idx_ff <= hdr_last_idx), "header index overrun")
   `MPK_ASSERT(a_load_shown, clock, reset, (cmd.byte_load |=> rsp_valid), "payload byte not presented")

endmodule

`default_nettype wire

// ===== rtl/mpeg_ps_packetizer.sv =====
// Top level of the program-stream packetizer: register port, controller, datapath.
// Depends on mpk_pkg, mpk_ctrl, mpk_dp (and mpk_div below it).
//
//   channel  ports        handshake         carries
//   req      req_*        valid / ready     one payload byte and segment info
//   rsp      rsp_*        valid / ready     one packet-stream byte with flags
//   csr      p* (APB)     psel/penable      pack_mode at 0x0, ac3_mode at 0x4
//
// A payload byte inside an open packet is accepted, then loaded into the
// output register. An item that opens a packet adds its header bytes
// (11 to 23) first; with pack_mode set it runs, before those, the multiply,
// the divider load, 56 divider steps and the done step.
// Reset is synchronous and clears the stream state; no clearing pass is needed.
// A stalled result port holds the output register and the controller waits.
`timescale 1ns / 1ps
`default_nettype none

module mpeg_ps_packetizer #(
   parameter int PKT_SIZE = mpk_pkg::MPK_PKT_SIZE
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [7:0]                         req_data_byte,
   input  wire  [7:0]                         req_stream_id,
   input  wire                                req_seg_first,
   input  wire  [mpk_pkg::MPK_OFF_W-1:0]      req_seg_bytes,
   input  wire  [mpk_pkg::MPK_TICK_W-1:0]     req_start_ticks,
   input  wire  [mpk_pkg::MPK_TICK_W-1:0]     req_end_ticks,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_run_last,
   output logic                               rsp_packet_end,
   output logic [mpk_pkg::MPK_PAD_W-1:0]      rsp_pad_owed,
   input  wire                                psel,
   input  wire                                penable,
   input  wire                                pwrite,
   input  wire  [2:0]                         paddr,
   input  wire  [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import mpk_pkg::*;

   logic        pack_ff, pack_in;
   logic        ac3_ff, ac3_in;
   logic        wr_en;
   mpk_cmd_type cmd;
   mpk_sts_type sts;

   // Register port
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      pack_in = pack_ff;
      ac3_in  = ac3_ff;
      if (wr_en) begin
         unique case (paddr[2])
            MPK_REG_PACK_MODE: pack_in = pwdata[0];
            MPK_REG_AC3_MODE:  ac3_in  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         MPK_REG_PACK_MODE: prdata = {31'b0, pack_ff};
         MPK_REG_AC3_MODE:  prdata = {31'b0, ac3_ff};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_ff <= 1'b1;
         ac3_ff  <= 1'b0;
      end else begin
         pack_ff <= pack_in;
         ac3_ff  <= ac3_in;
      end
   end

   mpk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mpk_dp #(
      .PKT_SIZE (PKT_SIZE)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .pack_mode       (pack_ff),
      .ac3_mode        (ac3_ff),
      .req_data_byte   (req_data_byte),
      .req_stream_id   (req_stream_id),
      .req_seg_first   (req_seg_first),
      .req_seg_bytes   (req_seg_bytes),
      .req_start_ticks (req_start_ticks),
      .req_end_ticks   (req_end_ticks),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_packet_end  (rsp_packet_end),
      .rsp_pad_owed    (rsp_pad_owed)
   );

endmodule

`default_nettype wire
